### sv/quaternion_to_euler_angles_assert.svh
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// same-cycle implication, clocked on clk, off while in reset
`define QTE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qte assertion failed");

// next-cycle implication
`define QTE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qte assertion failed");

`endif

### sv/qte_pkg.sv
`timescale 1ns / 1ps
package qte_pkg;
	localparam int ANGLE_ITERATIONS = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = FIFO_AW + 1;
	localparam int SQRT_STEPS = 29;
	localparam int CORDIC_LAT = ANGLE_ITERATIONS + 2;
	localparam int CW = 34;

	localparam logic [14:0] THRESH_RESET = 15'd16382;
	localparam logic signed [31:0] HALF_Q28 = 32'sd134217728;
	localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;
	localparam logic signed [CW-1:0] PI_Q29 = 34'sd1686629713;
	localparam logic signed [18:0] PI_Q13 = 19'sd25736;
	localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;

	typedef struct packed {
		logic signed [29:0] sp;
		logic               lock;
		logic signed [32:0] hy;
		logic signed [32:0] hx;
		logic signed [32:0] by;
		logic signed [32:0] bx;
	} item_t;

	function automatic logic [CW-1:0] atan_q29(input int i);
		logic [CW-1:0] r;
		case (i)
			0: r = 34'd421657428;
			1: r = 34'd248918915;
			2: r = 34'd131521918;
			3: r = 34'd66762579;
			4: r = 34'd33510843;
			5: r = 34'd16771758;
			6: r = 34'd8387925;
			7: r = 34'd4194219;
			8: r = 34'd2097141;
			9: r = 34'd1048575;
			default: r = (i < 30) ? (34'd1 << (29 - i)) : 34'd0;
		endcase
		return r;
	endfunction
endpackage

### sv/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// Converts a Q1.14 quaternion to heading and bank in Q3.13 radians and pitch in Q2.13 radians.
// A new request may be started every clock cycle; each gives one result, marked by a one-cycle
// done strobe, after the 29-stage square root pipeline for the pitch cosine and then the
// 16-step CORDIC pipelines. Results are presented once and cannot be held off, so they must
// be captured on the cycle done is high. busy rises only if the small queue between the
// classifier and the angle pipelines could fill, which the never-stalling back end rules out.
`include "quaternion_to_euler_angles_assert.svh"
module quaternion_to_euler_angles import qte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic               lock_threshold_we,
	input  logic [14:0]        lock_threshold_wdata,
	output logic               done,
	output logic signed [15:0] heading_angle,
	output logic signed [14:0] pitch_angle,
	output logic signed [15:0] bank_angle,
	output logic               gimbal_lock
);
	logic [2:0] stage_valid;
	logic fifo_push, q_valid;
	item_t front_item, q_item;
	logic [FIFO_CW-1:0] fifo_count;
	logic [FIFO_CW:0] occupancy;

	// queued plus in flight in the front end
	assign occupancy = (FIFO_CW+1)'(fifo_count) + (FIFO_CW+1)'(stage_valid[2])
		+ (FIFO_CW+1)'(stage_valid[1]) + (FIFO_CW+1)'(stage_valid[0]);
	assign busy = occupancy > (FIFO_CW+1)'(FIFO_DEPTH);

	qte_front u_front (
		.clk, .arst_n,
		.accept(start && !busy),
		.operation, .quat_w, .quat_x, .quat_y, .quat_z,
		.thr_we(lock_threshold_we), .thr_wdata(lock_threshold_wdata),
		.stage_valid, .item_valid(fifo_push), .item(front_item)
	);

	qte_fifo u_fifo (
		.clk, .arst_n,
		.push(fifo_push), .push_data(front_item),
		.pop_valid(q_valid), .pop_data(q_item), .count(fifo_count)
	);

	qte_back u_back (
		.clk, .arst_n,
		.in_valid(q_valid), .in_item(q_item),
		.done, .heading_angle, .pitch_angle, .bank_angle, .gimbal_lock
	);

	`QTE_ASSERT_IMP(a_lock_bank_zero, done && gimbal_lock, bank_angle == 16'sd0)
	`QTE_ASSERT_IMP(a_pitch_range, done, (pitch_angle <= 15'sd12868) && (pitch_angle >= -15'sd12868))
	`QTE_ASSERT_IMP(a_fifo_room, fifo_push, fifo_count < FIFO_CW'(FIFO_DEPTH))
endmodule

### sv/qte_front.sv
`timescale 1ns / 1ps
module qte_front import qte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               operation,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic               thr_we,
	input  logic [14:0]        thr_wdata,
	output logic [2:0]         stage_valid,
	output logic               item_valid,
	output item_t              item
);
	logic [14:0] thr_q;
	logic v_s1, v_s2, v_s3;
	logic op_s1;
	logic signed [31:0] wx_s1, yz_s1, xz_s1, wy_s1, xy_s1, wz_s1, xx_s1, yy_s1, zz_s1;
	logic signed [29:0] sp_s2;
	logic signed [32:0] hy_n_s2, hy_l_s2, hx_n_s2, hx_l_s2, by_s2, bx_s2;
	item_t item_s3;

	logic signed [33:0] sp_raw;
	logic signed [31:0] wy_sgn, wz_sgn;
	logic [28:0] mag;
	logic lock;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_RESET;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (thr_we) thr_q <= thr_wdata;
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: all nine products
	always_ff @(posedge clk) begin
		op_s1 <= operation;
		wx_s1 <= quat_w * quat_x;
		yz_s1 <= quat_y * quat_z;
		xz_s1 <= quat_x * quat_z;
		wy_s1 <= quat_w * quat_y;
		xy_s1 <= quat_x * quat_y;
		wz_s1 <= quat_w * quat_z;
		xx_s1 <= quat_x * quat_x;
		yy_s1 <= quat_y * quat_y;
		zz_s1 <= quat_z * quat_z;
	end

	always_comb begin
		sp_raw = (34'(wx_s1) - 34'(yz_s1)) <<< 1;
		wy_sgn = op_s1 ? -wy_s1 : wy_s1;
		wz_sgn = op_s1 ? -wz_s1 : wz_s1;
	end

	// stage 2: pitch sine, both heading candidates and the bank operands
	always_ff @(posedge clk) begin
		if (sp_raw > ONE_Q28) sp_s2 <= ONE_Q28[29:0];
		else if (sp_raw < -ONE_Q28) sp_s2 <= -(ONE_Q28[29:0]);
		else sp_s2 <= sp_raw[29:0];
		hy_n_s2 <= 33'(xz_s1) + 33'(wy_sgn);
		hy_l_s2 <= 33'(wy_sgn) - 33'(xz_s1);
		hx_n_s2 <= 33'(HALF_Q28) - 33'(xx_s1) - 33'(yy_s1);
		hx_l_s2 <= 33'(HALF_Q28) - 33'(yy_s1) - 33'(zz_s1);
		by_s2 <= 33'(xy_s1) + 33'(wz_sgn);
		bx_s2 <= 33'(HALF_Q28) - 33'(xx_s1) - 33'(zz_s1);
	end

	always_comb begin
		mag = sp_s2[29] ? 29'(-sp_s2) : sp_s2[28:0];
		lock = mag > {thr_q, 14'd0};
	end

	// stage 3: lock decision picks the heading operands
	always_ff @(posedge clk) begin
		item_s3.sp <= sp_s2;
		item_s3.lock <= lock;
		item_s3.hy <= lock ? hy_l_s2 : hy_n_s2;
		item_s3.hx <= lock ? hx_l_s2 : hx_n_s2;
		item_s3.by <= by_s2;
		item_s3.bx <= bx_s2;
	end

	assign stage_valid = {v_s1, v_s2, v_s3};
	assign item_valid = v_s3;
	assign item = item_s3;
endmodule

### sv/qte_fifo.sv
`timescale 1ns / 1ps
module qte_fifo import qte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  item_t              push_data,
	output logic               pop_valid,
	output item_t              pop_data,
	output logic [FIFO_CW-1:0] count
);
	item_t mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic rd_valid_q;
	item_t rd_data_q;
	logic pop;

	// the back end never stalls, so drain whenever anything is queued
	assign pop = (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + FIFO_CW'(push) - FIFO_CW'(pop);
			rd_valid_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_data;
		if (pop) rd_data_q <= mem[rd_ptr_q];
	end

	assign pop_valid = rd_valid_q;
	assign pop_data = rd_data_q;
	assign count = count_q;
endmodule

### sv/qte_cordic.sv
`timescale 1ns / 1ps
module qte_cordic import qte_pkg::*; (
	input  logic               clk,
	input  logic signed [32:0] y_in,
	input  logic signed [32:0] x_in,
	output logic signed [15:0] angle
);
	logic signed [CW-1:0] cx_q [ANGLE_ITERATIONS+1];
	logic signed [CW-1:0] cy_q [ANGLE_ITERATIONS+1];
	logic signed [CW-1:0] cz_q [ANGLE_ITERATIONS+1];
	logic                 zero_q [ANGLE_ITERATIONS+1];
	logic signed [15:0]   angle_q;

	logic signed [CW-1:0] zf;
	logic [CW-1:0] zmag;
	logic [17:0] rnd;
	logic signed [18:0] sr;

	// quadrant fold for left half-plane, plus zero-vector flag
	always_ff @(posedge clk) begin
		zero_q[0] <= (x_in == 33'sd0) && (y_in == 33'sd0);
		if (x_in[32]) begin
			cx_q[0] <= -CW'(x_in);
			cy_q[0] <= -CW'(y_in);
			cz_q[0] <= y_in[32] ? -PI_Q29 : PI_Q29;
		end else begin
			cx_q[0] <= CW'(x_in);
			cy_q[0] <= CW'(y_in);
			cz_q[0] <= '0;
		end
	end

	for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_iter
		logic signed [CW-1:0] dx, dy;
		assign dx = cy_q[i] >>> i;
		assign dy = cx_q[i] >>> i;
		always_ff @(posedge clk) begin
			zero_q[i+1] <= zero_q[i];
			if (cy_q[i] > 0) begin
				cx_q[i+1] <= cx_q[i] + dx;
				cy_q[i+1] <= cy_q[i] - dy;
				cz_q[i+1] <= cz_q[i] + signed'(atan_q29(i));
			end else begin
				cx_q[i+1] <= cx_q[i] - dx;
				cy_q[i+1] <= cy_q[i] + dy;
				cz_q[i+1] <= cz_q[i] - signed'(atan_q29(i));
			end
		end
	end

	// round half away from zero to q13, then saturate to pi
	always_comb begin
		zf = cz_q[ANGLE_ITERATIONS];
		zmag = zf[CW-1] ? CW'(-zf) : CW'(zf);
		rnd = 18'((zmag + CW'(1 << 15)) >> 16);
		sr = zf[CW-1] ? -signed'({1'b0, rnd}) : signed'({1'b0, rnd});
	end

	always_ff @(posedge clk) begin
		if (zero_q[ANGLE_ITERATIONS]) angle_q <= '0;
		else if (sr > PI_Q13) angle_q <= PI_Q13[15:0];
		else if (sr < -PI_Q13) angle_q <= -(PI_Q13[15:0]);
		else angle_q <= sr[15:0];
	end

	assign angle = angle_q;
endmodule

### sv/qte_back.sv
`timescale 1ns / 1ps
module qte_back import qte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  item_t              in_item,
	output logic               done,
	output logic signed [15:0] heading_angle,
	output logic signed [14:0] pitch_angle,
	output logic signed [15:0] bank_angle,
	output logic               gimbal_lock
);
	logic v_s1, v_s2;
	item_t it_s1, it_s2;
	logic [57:0] magsq_s1;
	logic signed [45:0] lp_s1;
	logic signed [14:0] lpitch_s2;
	logic [57:0] rem_s2;

	logic [57:0] sq_rem_q [SQRT_STEPS+1];
	logic [57:0] sq_root_q [SQRT_STEPS+1];
	item_t sq_it_q [SQRT_STEPS+1];
	logic signed [14:0] sq_lp_q [SQRT_STEPS+1];
	logic sq_v_q [SQRT_STEPS+1];

	logic cd_v_q [CORDIC_LAT];
	logic cd_lock_q [CORDIC_LAT];
	logic signed [14:0] cd_lp_q [CORDIC_LAT];

	logic done_q, lock_q;
	logic signed [15:0] heading_q, bank_q;
	logic signed [14:0] pitch_q;

	logic [28:0] mag_in;
	logic signed [45:0] lmag;
	logic [14:0] lr;
	logic [28:0] cosv;
	item_t sq_out;
	logic signed [15:0] h_ang, p_ang, b_ang;

	always_comb begin
		mag_in = in_item.sp[29] ? 29'(-in_item.sp) : in_item.sp[28:0];
		lmag = lp_s1[45] ? -lp_s1 : lp_s1;
		lr = 15'((lmag + 46'sd134217728) >>> 28);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		it_s1 <= in_item;
		magsq_s1 <= mag_in * mag_in;
		lp_s1 <= HALF_PI_Q13 * in_item.sp;
		it_s2 <= it_s1;
		rem_s2 <= (58'd1 << 56) - magsq_s1;
		lpitch_s2 <= lp_s1[45] ? -signed'(lr) : signed'(lr);
	end

	assign sq_rem_q[0] = rem_s2;
	assign sq_root_q[0] = '0;
	assign sq_it_q[0] = it_s2;
	assign sq_lp_q[0] = lpitch_s2;
	assign sq_v_q[0] = v_s2;

	// one result bit per stage, largest first
	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		logic [57:0] sbit, trial;
		assign sbit = 58'd1 << (2 * (SQRT_STEPS - 1 - j));
		assign trial = sq_root_q[j] + sbit;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_q[j+1] <= 1'b0;
			else sq_v_q[j+1] <= sq_v_q[j];
		end
		always_ff @(posedge clk) begin
			sq_it_q[j+1] <= sq_it_q[j];
			sq_lp_q[j+1] <= sq_lp_q[j];
			if (sq_rem_q[j] >= trial) begin
				sq_rem_q[j+1] <= sq_rem_q[j] - trial;
				sq_root_q[j+1] <= (sq_root_q[j] >> 1) + sbit;
			end else begin
				sq_rem_q[j+1] <= sq_rem_q[j];
				sq_root_q[j+1] <= sq_root_q[j] >> 1;
			end
		end
	end

	assign sq_out = sq_it_q[SQRT_STEPS];
	assign cosv = sq_root_q[SQRT_STEPS][28:0];

	qte_cordic u_heading (.clk, .y_in(sq_out.hy), .x_in(sq_out.hx), .angle(h_ang));
	qte_cordic u_pitch (.clk, .y_in(33'(sq_out.sp)), .x_in({4'd0, cosv}), .angle(p_ang));
	qte_cordic u_bank (.clk, .y_in(sq_out.by), .x_in(sq_out.bx), .angle(b_ang));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cd_v_q[0] <= 1'b0;
		else cd_v_q[0] <= sq_v_q[SQRT_STEPS];
	end
	always_ff @(posedge clk) begin
		cd_lock_q[0] <= sq_out.lock;
		cd_lp_q[0] <= sq_lp_q[SQRT_STEPS];
	end
	for (genvar k = 1; k < CORDIC_LAT; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cd_v_q[k] <= 1'b0;
			else cd_v_q[k] <= cd_v_q[k-1];
		end
		always_ff @(posedge clk) begin
			cd_lock_q[k] <= cd_lock_q[k-1];
			cd_lp_q[k] <= cd_lp_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= cd_v_q[CORDIC_LAT-1];
	end

	always_ff @(posedge clk) begin
		lock_q <= cd_lock_q[CORDIC_LAT-1];
		heading_q <= h_ang;
		if (cd_lock_q[CORDIC_LAT-1]) begin
			pitch_q <= cd_lp_q[CORDIC_LAT-1];
			bank_q <= '0;
		end else begin
			if (p_ang > HALF_PI_Q13) pitch_q <= HALF_PI_Q13[14:0];
			else if (p_ang < -HALF_PI_Q13) pitch_q <= -(HALF_PI_Q13[14:0]);
			else pitch_q <= p_ang[14:0];
			bank_q <= b_ang;
		end
	end

	assign done = done_q;
	assign heading_angle = heading_q;
	assign pitch_angle = pitch_q;
	assign bank_angle = bank_q;
	assign gimbal_lock = lock_q;
endmodule
